// File: rtl/afc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the admittance force controller.
// Holds the sequencer states, the datapath command struct and the Q16.16 saturation helper.
package afc_pkg;

   localparam int QW = 32;   // Q16.16 word width
   localparam int FRAC = 16; // fraction bits

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_INV_MASS  = 3'd0;
   localparam logic [2:0] REG_DAMPING   = 3'd1;
   localparam logic [2:0] REG_STIFFNESS = 3'd2;
   localparam logic [2:0] REG_TIME_STEP = 3'd3;
   localparam logic [2:0] REG_INTEGRAL  = 3'd4;
   localparam logic [2:0] REG_MODE      = 3'd5;
   localparam logic [2:0] REG_INIT_POS  = 3'd6;

   // Reset values of the registers.
   localparam logic [30:0] RST_INV_MASS  = 31'd1872;
   localparam logic [30:0] RST_DAMPING   = 31'd36044800;
   localparam logic [30:0] RST_STIFFNESS = 31'd65536000;
   localparam logic [16:0] RST_TIME_STEP = 17'd5898;
   localparam logic [30:0] RST_INTEGRAL  = 31'd32768;
   localparam logic [2:0]  RST_MODE      = 3'd0;

   // Mode flag bit positions.
   localparam int MODE_SPRING   = 0;
   localparam int MODE_OUT_SPD  = 1;
   localparam int MODE_INTEGRAL = 2;

   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DIFF,
      ST_I_MUL1, ST_I_ADD1, ST_I_MUL2, ST_I_ADD2,
      ST_D_MUL, ST_D_ADD,
      ST_K_SUB, ST_K_MUL, ST_K_ADD,
      ST_M_MUL, ST_M_ADD,
      ST_V_MUL, ST_V_ADD,
      ST_P_MUL, ST_P_ADD,
      ST_RESTART, ST_DONE
   } state_type;

   typedef enum logic [1:0] {A_FE, A_TMP, A_SPEED, A_ACC} a_sel_type;
   typedef enum logic [2:0] {B_DT, B_IG, B_DG, B_KG, B_IM} b_sel_type;
   typedef enum logic [2:0] {L_MF, L_FE, L_ACC, L_SPEED, L_POS, L_ZERO} lhs_sel_type;
   typedef enum logic [1:0] {R_TF, R_TP, R_MUL} rhs_sel_type;
   typedef enum logic [1:0] {D_ACC, D_TMP, D_SPEED, D_POS} dst_type;

   typedef struct packed {
      logic        load_in;
      a_sel_type   a_sel;
      b_sel_type   b_sel;
      logic        alu_en;
      lhs_sel_type lhs_sel;
      rhs_sel_type rhs_sel;
      logic        sub;
      dst_type     dst;
      logic        flag_clr;
      logic        restart;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [30:0]        inv_mass;
      logic [30:0]        damping;
      logic [30:0]        stiffness;
      logic [16:0]        time_step;
      logic [30:0]        integral;
      logic signed [31:0] init_pos;
   } cfg_type;

   typedef struct packed {
      logic               clip;
      logic signed [31:0] val;
   } sat_type;

   // Clamp a wide signed value into the signed 32-bit range.
   function automatic sat_type sat_q(input logic signed [47:0] x);
      sat_type r;
      if (x > 48'sh0000_7FFF_FFFF) begin
         r.clip = 1'b1;
         r.val  = 32'sh7FFF_FFFF;
      end else if (x < -48'sh0000_8000_0000) begin
         r.clip = 1'b1;
         r.val  = 32'sh8000_0000;
      end else begin
         r.clip = 1'b0;
         r.val  = x[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/admittance_force_controller.sv
`timescale 1ns / 1ps
// Top level of the one-axis admittance force controller.
// Holds the configuration registers and result register; uses afc_pkg, afc_ctrl and afc_dp.
//
// A control sample steps through the difference, the integral term (optional), damping,
// the spring term (optional), mass, speed and position; a restart item goes to delivery.
// A new item is taken only after the last result is loaded, as the single shared multiplier
// and adder serve every term of the acceleration sum in turn.
// Reset (synchronous, active high) loads the register defaults, zeroes speed and position.
module admittance_force_controller
   import afc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Input items.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // desired_force, measured_force, target_position, force_error
   input  logic         req_tuser,  // kind
   // Result items.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // command
   output logic         rsp_tuser,  // saturated
   // Configuration writes.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   // Configuration registers. Writes are always taken; an index past the last
   // register is dropped.
   logic [30:0]        inv_mass_ff, damping_ff, stiffness_ff, integral_ff;
   logic [16:0]        time_step_ff;
   logic [2:0]         mode_ff;
   logic signed [31:0] init_pos_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff  <= RST_INV_MASS;
         damping_ff   <= RST_DAMPING;
         stiffness_ff <= RST_STIFFNESS;
         time_step_ff <= RST_TIME_STEP;
         integral_ff  <= RST_INTEGRAL;
         mode_ff      <= RST_MODE;
         init_pos_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_INV_MASS:  inv_mass_ff  <= csr_data[30:0];
            REG_DAMPING:   damping_ff   <= csr_data[30:0];
            REG_STIFFNESS: stiffness_ff <= csr_data[30:0];
            REG_TIME_STEP: time_step_ff <= csr_data[16:0];
            REG_INTEGRAL:  integral_ff  <= csr_data[30:0];
            REG_MODE:      mode_ff      <= csr_data[2:0];
            REG_INIT_POS:  init_pos_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   cfg_type cfg;

   always_comb begin
      cfg.inv_mass  = inv_mass_ff;
      cfg.damping   = damping_ff;
      cfg.stiffness = stiffness_ff;
      cfg.time_step = time_step_ff;
      cfg.integral  = integral_ff;
      cfg.init_pos  = init_pos_ff;
   end

   // The result register parts the two sides: the sequencer can take a new item
   // while the previous result still waits for the consumer.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff;
   logic               rsp_flag_ff;
   logic               out_free;
   cmd_type            cmd;
   logic signed [31:0] speed, position;
   logic               saturated;

   assign out_free = !rsp_valid_ff || rsp_tready;

   afc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .mode      (mode_ff),
      .out_free  (out_free),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   afc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg),
      .in_desired_force   (req_tdata[31:0]),
      .in_measured_force  (req_tdata[63:32]),
      .in_target_position (req_tdata[95:64]),
      .in_force_error     (req_tdata[127:96]),
      .speed              (speed),
      .position           (position),
      .saturated          (saturated)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // In speed output mode the command is the speed; after a restart that is zero.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= mode_ff[MODE_OUT_SPD] ? speed : position;
         rsp_flag_ff <= saturated;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_rsp))
      else $error("result appeared without a load from the sequencer");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> out_free)
      else $error("result register overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == KIND_RESTART) |=> ##1 !saturated)
      else $error("restart item left the clamp flag set");

endmodule

// File: rtl/afc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the admittance force controller.
// Steps the shared multiplier and adder through one sample, or applies a restart item; uses afc_pkg.
module afc_ctrl
   import afc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   input  logic [2:0] mode,
   input  logic       out_free,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == KIND_RESTART) ? ST_RESTART : ST_DIFF;
            end
         end
         ST_DIFF:    state_in = mode[MODE_INTEGRAL] ? ST_I_MUL1 : ST_D_MUL;
         ST_I_MUL1:  state_in = ST_I_ADD1;
         ST_I_ADD1:  state_in = ST_I_MUL2;
         ST_I_MUL2:  state_in = ST_I_ADD2;
         ST_I_ADD2:  state_in = ST_D_MUL;
         ST_D_MUL:   state_in = ST_D_ADD;
         ST_D_ADD:   state_in = mode[MODE_SPRING] ? ST_K_SUB : ST_M_MUL;
         ST_K_SUB:   state_in = ST_K_MUL;
         ST_K_MUL:   state_in = ST_K_ADD;
         ST_K_ADD:   state_in = ST_M_MUL;
         ST_M_MUL:   state_in = ST_M_ADD;
         ST_M_ADD:   state_in = ST_V_MUL;
         ST_V_MUL:   state_in = ST_V_ADD;
         ST_V_ADD:   state_in = ST_P_MUL;
         ST_P_MUL:   state_in = ST_P_ADD;
         ST_P_ADD:   state_in = ST_DONE;
         ST_RESTART: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd          = '0;
      cmd.a_sel    = A_FE;
      cmd.b_sel    = B_DT;
      cmd.lhs_sel  = L_ZERO;
      cmd.rhs_sel  = R_MUL;
      cmd.dst      = D_ACC;
      cmd.load_in  = req_ready && req_valid;
      unique case (state_ff)
         ST_IDLE: ;
         ST_DIFF: begin
            cmd.alu_en = 1'b1; cmd.lhs_sel = L_MF; cmd.rhs_sel = R_TF;
            cmd.sub = 1'b1; cmd.dst = D_ACC; cmd.flag_clr = 1'b1;
         end
         ST_I_MUL1: begin
            cmd.a_sel = A_FE; cmd.b_sel = B_DT;
         end
         ST_I_ADD1: begin
            cmd.alu_en = 1'b1; cmd.lhs_sel = L_FE; cmd.dst = D_TMP;
         end
         ST_I_MUL2: begin
            cmd.a_sel = A_TMP; cmd.b_sel = B_IG;
         end
         ST_I_ADD2: begin
            cmd.alu_en = 1'b1; cmd.lhs_sel = L_ACC; cmd.dst = D_ACC;
         end
         ST_D_MUL: begin
            cmd.a_sel = A_SPEED; cmd.b_sel = B_DG;
         end
         ST_D_ADD: begin
            cmd.alu_en = 1'b1; cmd.lhs_sel = L_ACC; cmd.sub = 1'b1; cmd.dst = D_ACC;
         end
         ST_K_SUB: begin
            cmd.alu_en = 1'b1; cmd.lhs_sel = L_POS; cmd.rhs_sel = R_TP;
            cmd.sub = 1'b1; cmd.dst = D_TMP;
         end
         ST_K_MUL: begin
            cmd.a_sel = A_TMP; cmd.b_sel = B_KG;
         end
         ST_K_ADD: begin
            cmd.alu_en = 1'b1; cmd.lhs_sel = L_ACC; cmd.sub = 1'b1; cmd.dst = D_ACC;
         end
         ST_M_MUL: begin
            cmd.a_sel = A_ACC; cmd.b_sel = B_IM;
         end
         ST_M_ADD: begin
            cmd.alu_en = 1'b1; cmd.lhs_sel = L_ZERO; cmd.dst = D_TMP;
         end
         ST_V_MUL: begin
            cmd.a_sel = A_TMP; cmd.b_sel = B_DT;
         end
         ST_V_ADD: begin
            cmd.alu_en = 1'b1; cmd.lhs_sel = L_SPEED; cmd.dst = D_SPEED;
         end
         ST_P_MUL: begin
            cmd.a_sel = A_SPEED; cmd.b_sel = B_DT;
         end
         ST_P_ADD: begin
            cmd.alu_en = 1'b1; cmd.lhs_sel = L_POS; cmd.dst = D_POS;
         end
         ST_RESTART: cmd.restart = 1'b1;
         ST_DONE:    cmd.load_rsp = out_free;
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_in |=> !req_ready)
      else $error("sequencer accepted an item but stayed ready");

   assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> cmd.load_rsp || !out_free)
      else $error("restart did not lead straight to result delivery");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !cmd.alu_en && !cmd.restart)
      else $error("result loaded while the datapath is still updating");

endmodule

// File: rtl/afc_dp.sv
`timescale 1ns / 1ps
// Datapath of the admittance force controller: operand latches, one shared
// registered multiplier, a saturating adder and the speed and position state; uses afc_pkg.
module afc_dp
   import afc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  cfg_type            cfg,
   input  logic signed [31:0] in_desired_force,
   input  logic signed [31:0] in_measured_force,
   input  logic signed [31:0] in_target_position,
   input  logic signed [31:0] in_force_error,
   output logic signed [31:0] speed,
   output logic signed [31:0] position,
   output logic               saturated
);

   logic signed [31:0] tf_ff, mf_ff, tp_ff, fe_ff;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] tmp_ff, tmp_in;
   logic signed [31:0] speed_ff, speed_in;
   logic signed [31:0] pos_ff, pos_in;
   logic               flag_ff, flag_in;
   logic signed [63:0] prod_ff;

   logic signed [31:0] mul_a, mul_b, lhs, rhs;
   logic signed [33:0] sum;
   sat_type            mul_q, alu_q;

   // Payload latches for the item under work.
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         tf_ff <= in_desired_force;
         mf_ff <= in_measured_force;
         tp_ff <= in_target_position;
         fe_ff <= in_force_error;
      end
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
      tmp_ff  <= tmp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         pos_ff   <= '0;
         flag_ff  <= 1'b0;
      end else begin
         speed_ff <= speed_in;
         pos_ff   <= pos_in;
         flag_ff  <= flag_in;
      end
   end

   always_comb begin
      case (cmd.a_sel)
         A_FE:    mul_a = fe_ff;
         A_TMP:   mul_a = tmp_ff;
         A_SPEED: mul_a = speed_ff;
         A_ACC:   mul_a = acc_ff;
         default: mul_a = fe_ff;
      endcase
      case (cmd.b_sel)
         B_DT:    mul_b = {15'd0, cfg.time_step};
         B_IG:    mul_b = {1'b0, cfg.integral};
         B_DG:    mul_b = {1'b0, cfg.damping};
         B_KG:    mul_b = {1'b0, cfg.stiffness};
         B_IM:    mul_b = {1'b0, cfg.inv_mass};
         default: mul_b = {15'd0, cfg.time_step};
      endcase
   end

   // The arithmetic shift floors the product, as the fixed-point format requires.
   assign mul_q = sat_q(prod_ff[63:FRAC]);

   always_comb begin
      case (cmd.lhs_sel)
         L_MF:    lhs = mf_ff;
         L_FE:    lhs = fe_ff;
         L_ACC:   lhs = acc_ff;
         L_SPEED: lhs = speed_ff;
         L_POS:   lhs = pos_ff;
         default: lhs = '0;
      endcase
      case (cmd.rhs_sel)
         R_TF:    rhs = tf_ff;
         R_TP:    rhs = tp_ff;
         default: rhs = mul_q.val;
      endcase
      sum = cmd.sub ? {{2{lhs[31]}}, lhs} - {{2{rhs[31]}}, rhs}
                    : {{2{lhs[31]}}, lhs} + {{2{rhs[31]}}, rhs};
      alu_q = sat_q({{14{sum[33]}}, sum});
   end

   always_comb begin
      acc_in   = acc_ff;
      tmp_in   = tmp_ff;
      speed_in = speed_ff;
      pos_in   = pos_ff;
      flag_in  = flag_ff;
      if (cmd.restart) begin
         speed_in = '0;
         pos_in   = cfg.init_pos;
         flag_in  = 1'b0;
      end else if (cmd.alu_en) begin
         case (cmd.dst)
            D_ACC:   acc_in   = alu_q.val;
            D_TMP:   tmp_in   = alu_q.val;
            D_SPEED: speed_in = alu_q.val;
            D_POS:   pos_in   = alu_q.val;
            default: acc_in   = alu_q.val;
         endcase
         flag_in = (cmd.flag_clr ? 1'b0 : flag_ff) | alu_q.clip
                   | ((cmd.rhs_sel == R_MUL) && mul_q.clip);
      end
   end

   assign speed     = speed_ff;
   assign position  = pos_ff;
   assign saturated = flag_ff;

endmodule
